// File: hdl/led_matrix_scan_driver_defines.svh
// assertion macros for the led matrix scan driver checker
// depends on nothing; included by the checker file only
`ifndef LED_MATRIX_SCAN_DRIVER_DEFINES_SVH
`define LED_MATRIX_SCAN_DRIVER_DEFINES_SVH

// same-cycle implication, quiet during reset
`define LMSD_ASSERT_SAME(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, quiet during reset
`define LMSD_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/lmsd_pkg.sv
// shared constants and types for the led matrix scan driver
// no dependencies; imported by the top level and the checker
`default_nettype none

package lmsd_pkg;

    // panel geometry
    localparam int PANEL_COLUMNS  = 64;
    localparam int PANEL_ROWS     = 32;
    localparam int PLANE_COUNT    = 5;
    localparam int COLOR_BITS     = 5;

    localparam int SCAN_ROWS      = PANEL_ROWS / 4;
    localparam int HALF_ROWS      = PANEL_ROWS / 2;
    localparam int SHIFTS_PER_ROW = 2 * PANEL_COLUMNS;

    // widths
    localparam int COL_W   = $clog2(SHIFTS_PER_ROW);
    localparam int X_W     = $clog2(PANEL_COLUMNS);
    localparam int Y_W     = $clog2(HALF_ROWS);
    localparam int ROW_W   = $clog2(SCAN_ROWS);
    localparam int PLANE_W = 3;
    localparam int ADDR_W  = 1 + Y_W + X_W;
    localparam int MEM_DEPTH = 1 << ADDR_W;

    localparam logic [7:0] BRIGHT_RESET = 8'd255;

    // command codes
    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_SWAP  = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;
    localparam logic [1:0] CMD_SCAN  = 2'd3;

    typedef struct packed {
        logic [COLOR_BITS-1:0] red;
        logic [COLOR_BITS-1:0] green;
        logic [COLOR_BITS-1:0] blue;
    } pixel_t;

    typedef struct packed {
        logic [ROW_W-1:0]   row;
        logic [PLANE_W-1:0] plane;
        logic               latch;
        logic [7:0]         duty;
    } scan_meta_t;

endpackage

`default_nettype wire

// File: hdl/led_matrix_scan_driver.sv
// top level of the led matrix scan driver: command decode, frame memories, scan counters
// depends on lmsd_pkg
`default_nettype none

// led_matrix_scan_driver
//
// command channel (in_valid / in_ready): write pixel, swap buffers, clear draw
// buffer, scan step. only a scan step produces a result item on the output
// channel (out_valid / out_ready); the other commands produce nothing.
// config channel (cfg_valid / cfg_ready) loads the brightness register; it is
// always ready and should only be written while the block is idle.
//
// the two pixels of a scan step item are read from the frame memories into the
// read stage at the edge that accepts it, and the item moves on into the output
// register once that register is empty or its result item is being taken.
// throughput is one item per cycle for write, swap and scan while in_ready is high.
// a clear command holds in_ready low while it sweeps the draw buffer one entry
// per cycle (both half-panel memories written together).
//
// reset: all control state clears and a clearing pass zeroes both buffers
// with in_ready low. brightness resets to 255.
// when the receiver stalls the result item holds in the output register; one
// more scan step can be read into the stage behind it, then in_ready drops.
module led_matrix_scan_driver
    import lmsd_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,

    input  wire logic              in_valid,
    output      logic              in_ready,
    input  wire logic [1:0]        cmd,
    input  wire logic signed [7:0] pix_x,
    input  wire logic signed [6:0] pix_y,
    input  wire logic [4:0]        red_in,
    input  wire logic [4:0]        green_in,
    input  wire logic [4:0]        blue_in,

    output      logic              out_valid,
    input  wire logic              out_ready,
    output      logic              upper_red,
    output      logic              upper_green,
    output      logic              upper_blue,
    output      logic              lower_red,
    output      logic              lower_green,
    output      logic              lower_blue,
    output      logic [2:0]        row_address,
    output      logic [2:0]        plane_index,
    output      logic              latch_pulse,
    output      logic [7:0]        enable_duty,

    input  wire logic              cfg_valid,
    output      logic              cfg_ready,
    input  wire logic [7:0]        brightness
);

    // frame memories: upper half rows and lower half rows of the panel.
    // address is {buffer, row within half, column}
    pixel_t mem_up [MEM_DEPTH];
    pixel_t mem_lo [MEM_DEPTH];

    // control state
    logic [7:0]         bright_reg;
    logic               disp_sel_reg;      // 0: buffer 0 drawn, buffer 1 shown
    logic [COL_W-1:0]   col_cnt_reg;
    logic [ROW_W-1:0]   row_cnt_reg;
    logic [PLANE_W-1:0] plane_cnt_reg;
    logic               clr_busy_reg;
    logic               clr_all_reg;       // reset pass covers both buffers
    logic [ADDR_W-1:0]  clr_cnt_reg;

    // pipeline
    logic               s1_valid_reg;
    scan_meta_t         s1_meta_reg;
    pixel_t             rdata_up_reg;
    pixel_t             rdata_lo_reg;
    logic               out_valid_reg;

    logic               s1_adv;
    logic               in_acc;
    logic               scan_acc;
    logic               write_acc;
    logic               clear_acc;
    logic               swap_acc;

    // ---------------------------------------------------------------
    // handshakes
    // ---------------------------------------------------------------
    assign s1_adv   = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !clr_busy_reg && (!s1_valid_reg || s1_adv);
    assign in_acc   = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    // ---------------------------------------------------------------
    // pixel write decode; out-of-panel coordinates are dropped
    // ---------------------------------------------------------------
    logic              x_ok;
    logic              y_ok;
    logic [5:0]        y_u;
    logic              y_lower;
    logic [5:0]        y_half;
    logic [7:0]        x_u;
    logic [ADDR_W-1:0] wr_addr;
    pixel_t            wr_data;
    logic              we_up;
    logic              we_lo;

    always_comb
    begin
        x_ok    = !pix_x[7] && (int'({1'b0, pix_x[6:0]}) < PANEL_COLUMNS);
        y_ok    = !pix_y[6] && (int'(pix_y[5:0]) < PANEL_ROWS);
        y_u     = pix_y[5:0];
        x_u     = pix_x;
        y_lower = (int'(y_u) >= HALF_ROWS);
        y_half  = y_lower ? (y_u - 6'(HALF_ROWS)) : y_u;
    end

    assign write_acc = in_acc && (cmd == CMD_WRITE) && x_ok && y_ok;
    assign swap_acc  = in_acc && (cmd == CMD_SWAP);
    assign clear_acc = in_acc && (cmd == CMD_CLEAR);
    assign scan_acc  = in_acc && (cmd == CMD_SCAN);

    // the clearing sweep owns the write port while it runs
    logic              clr_last;
    logic [ADDR_W-1:0] clr_addr;

    always_comb
    begin
        clr_last = clr_all_reg ? (&clr_cnt_reg) : (&clr_cnt_reg[ADDR_W-2:0]);
        clr_addr = clr_all_reg ? clr_cnt_reg : {disp_sel_reg, clr_cnt_reg[ADDR_W-2:0]};
        if (clr_busy_reg)
        begin
            wr_addr = clr_addr;
            wr_data = '0;
            we_up   = 1'b1;
            we_lo   = 1'b1;
        end
        else
        begin
            wr_addr = {disp_sel_reg, Y_W'(y_half), X_W'(x_u)};
            wr_data = {red_in, green_in, blue_in};
            we_up   = write_acc && !y_lower;
            we_lo   = write_acc && y_lower;
        end
    end

    // ---------------------------------------------------------------
    // scan address: both halves read the same address.
    // first half of the shifts shows rows r+S / r+3S, second half r / r+2S
    // ---------------------------------------------------------------
    logic               grp_upper;
    logic [COL_W-1:0]   col_x;
    logic [Y_W-1:0]     scan_y;
    logic [ADDR_W-1:0]  rd_addr;
    logic               latch_now;

    always_comb
    begin
        grp_upper = (int'(col_cnt_reg) < PANEL_COLUMNS);
        col_x     = grp_upper ? col_cnt_reg : (col_cnt_reg - COL_W'(PANEL_COLUMNS));
        scan_y    = Y_W'(row_cnt_reg) + (grp_upper ? Y_W'(SCAN_ROWS) : '0);
        rd_addr   = {~disp_sel_reg, scan_y, X_W'(col_x)};
        latch_now = (col_cnt_reg == COL_W'(SHIFTS_PER_ROW - 1));
    end

    // frame memories, one write and one registered read each
    always_ff @(posedge clk)
    begin
        if (we_up)
        begin
            mem_up[wr_addr] <= wr_data;
        end
        if (we_lo)
        begin
            mem_lo[wr_addr] <= wr_data;
        end
        if (scan_acc)
        begin
            rdata_up_reg <= mem_up[rd_addr];
            rdata_lo_reg <= mem_lo[rd_addr];
        end
    end

    // ---------------------------------------------------------------
    // scan counters
    // ---------------------------------------------------------------
    logic [COL_W-1:0]   col_cnt_next;
    logic [ROW_W-1:0]   row_cnt_next;
    logic [PLANE_W-1:0] plane_cnt_next;

    always_comb
    begin
        col_cnt_next   = col_cnt_reg;
        row_cnt_next   = row_cnt_reg;
        plane_cnt_next = plane_cnt_reg;
        if (scan_acc)
        begin
            if (latch_now)
            begin
                col_cnt_next = '0;
                if (row_cnt_reg == ROW_W'(SCAN_ROWS - 1))
                begin
                    row_cnt_next = '0;
                    if (plane_cnt_reg == PLANE_W'(PLANE_COUNT - 1))
                    begin
                        plane_cnt_next = '0;
                    end
                    else
                    begin
                        plane_cnt_next = plane_cnt_reg + 1'b1;
                    end
                end
                else
                begin
                    row_cnt_next = row_cnt_reg + 1'b1;
                end
            end
            else
            begin
                col_cnt_next = col_cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bright_reg    <= BRIGHT_RESET;
            disp_sel_reg  <= 1'b0;
            col_cnt_reg   <= '0;
            row_cnt_reg   <= '0;
            plane_cnt_reg <= '0;
            clr_busy_reg  <= 1'b1;
            clr_all_reg   <= 1'b1;
            clr_cnt_reg   <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                bright_reg <= brightness;
            end
            if (swap_acc)
            begin
                disp_sel_reg <= ~disp_sel_reg;
            end
            col_cnt_reg   <= col_cnt_next;
            row_cnt_reg   <= row_cnt_next;
            plane_cnt_reg <= plane_cnt_next;

            // clearing sweep
            if (clear_acc)
            begin
                clr_busy_reg <= 1'b1;
                clr_all_reg  <= 1'b0;
                clr_cnt_reg  <= '0;
            end
            else if (clr_busy_reg)
            begin
                if (clr_last)
                begin
                    clr_busy_reg <= 1'b0;
                    clr_all_reg  <= 1'b0;
                end
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end

            // read stage
            if (scan_acc)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end

            // output register
            if (s1_adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // item metadata travels with the memory read
    always_ff @(posedge clk)
    begin
        if (scan_acc)
        begin
            s1_meta_reg.row   <= row_cnt_reg;
            s1_meta_reg.plane <= plane_cnt_reg;
            s1_meta_reg.latch <= latch_now;
            s1_meta_reg.duty  <= latch_now ? bright_reg : 8'd0;
        end
    end

    // ---------------------------------------------------------------
    // bit-plane select; planes past the colour depth shift out to zero
    // ---------------------------------------------------------------
    logic [COLOR_BITS-1:0] ur_sh;
    logic [COLOR_BITS-1:0] ug_sh;
    logic [COLOR_BITS-1:0] ub_sh;
    logic [COLOR_BITS-1:0] lr_sh;
    logic [COLOR_BITS-1:0] lg_sh;
    logic [COLOR_BITS-1:0] lb_sh;

    always_comb
    begin
        ur_sh = rdata_up_reg.red   >> s1_meta_reg.plane;
        ug_sh = rdata_up_reg.green >> s1_meta_reg.plane;
        ub_sh = rdata_up_reg.blue  >> s1_meta_reg.plane;
        lr_sh = rdata_lo_reg.red   >> s1_meta_reg.plane;
        lg_sh = rdata_lo_reg.green >> s1_meta_reg.plane;
        lb_sh = rdata_lo_reg.blue  >> s1_meta_reg.plane;
    end

    logic       ur_reg;
    logic       ug_reg;
    logic       ub_reg;
    logic       lr_reg;
    logic       lg_reg;
    logic       lb_reg;
    logic [2:0] row_out_reg;
    logic [2:0] plane_out_reg;
    logic       latch_out_reg;
    logic [7:0] duty_out_reg;

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            ur_reg        <= ur_sh[0];
            ug_reg        <= ug_sh[0];
            ub_reg        <= ub_sh[0];
            lr_reg        <= lr_sh[0];
            lg_reg        <= lg_sh[0];
            lb_reg        <= lb_sh[0];
            row_out_reg   <= 3'(s1_meta_reg.row);
            plane_out_reg <= s1_meta_reg.plane;
            latch_out_reg <= s1_meta_reg.latch;
            duty_out_reg  <= s1_meta_reg.duty;
        end
    end

    assign out_valid   = out_valid_reg;
    assign upper_red   = ur_reg;
    assign upper_green = ug_reg;
    assign upper_blue  = ub_reg;
    assign lower_red   = lr_reg;
    assign lower_green = lg_reg;
    assign lower_blue  = lb_reg;
    assign row_address = row_out_reg;
    assign plane_index = plane_out_reg;
    assign latch_pulse = latch_out_reg;
    assign enable_duty = duty_out_reg;

endmodule

`default_nettype wire

// File: hdl/lmsd_checker.sv
// port-level assertion checker for the led matrix scan driver, bound to the top level
// depends on lmsd_pkg and led_matrix_scan_driver_defines.svh
`default_nettype none

`include "led_matrix_scan_driver_defines.svh"

module lmsd_checker
    import lmsd_pkg::*;
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic       upper_red,
    input wire logic       upper_green,
    input wire logic       upper_blue,
    input wire logic       lower_red,
    input wire logic       lower_green,
    input wire logic       lower_blue,
    input wire logic [2:0] plane_index,
    input wire logic       latch_pulse,
    input wire logic [7:0] enable_duty
);

    // a stalled result item stays offered
    `LMSD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid,
        "result item dropped while stalled")

    // output enable stays off while columns are still shifting
    `LMSD_ASSERT_SAME(a_duty_zero, clk, rst_n, out_valid && !latch_pulse, enable_duty == 8'd0,
        "enable duty nonzero on a shift item")

    // plane counter never passes the plane count
    `LMSD_ASSERT_SAME(a_plane_range, clk, rst_n, out_valid,
        int'(plane_index) < PLANE_COUNT, "plane index out of range")

    // planes beyond the colour depth carry no colour bits
    `LMSD_ASSERT_SAME(a_plane_dark, clk, rst_n, out_valid && (int'(plane_index) >= COLOR_BITS),
        !(upper_red || upper_green || upper_blue || lower_red || lower_green || lower_blue),
        "colour bit set on a plane past the colour depth")

endmodule

bind led_matrix_scan_driver lmsd_checker u_lmsd_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .upper_red   (upper_red),
    .upper_green (upper_green),
    .upper_blue  (upper_blue),
    .lower_red   (lower_red),
    .lower_green (lower_green),
    .lower_blue  (lower_blue),
    .plane_index (plane_index),
    .latch_pulse (latch_pulse),
    .enable_duty (enable_duty)
);

`default_nettype wire

// File: bench/tb_led_matrix_scan_driver.sv
// self-checking bench for led_matrix_scan_driver: directed and random command streams
// with a cycle-free model of the frame buffers and scan counters; depends on lmsd_pkg
`timescale 1ns / 100ps

module tb_led_matrix_scan_driver;
    import lmsd_pkg::*;

    // one command item as it goes onto the command channel
    typedef struct {
        logic [1:0] op;
        logic [7:0] pix_x;
        logic [6:0] pix_y;
        logic [4:0] red;
        logic [4:0] green;
        logic [4:0] blue;
        bit         wait_idle;   // hold this item back until every shift has come out
    } panel_cmd_t;

    // one column shift as the panel pins should show it
    typedef struct {
        logic       upper_red;
        logic       upper_green;
        logic       upper_blue;
        logic       lower_red;
        logic       lower_green;
        logic       lower_blue;
        logic [2:0] row_address;
        logic [2:0] plane_index;
        logic       latch_pulse;
        logic [7:0] enable_duty;
    } shift_result_t;

    // dut ports; the inputs are all known from time zero
    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [1:0] cmd = CMD_WRITE;
    logic [7:0] pix_x = '0;
    logic [6:0] pix_y = '0;
    logic [4:0] red_in = '0;
    logic [4:0] green_in = '0;
    logic [4:0] blue_in = '0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic       upper_red;
    logic       upper_green;
    logic       upper_blue;
    logic       lower_red;
    logic       lower_green;
    logic       lower_blue;
    logic [2:0] row_address;
    logic [2:0] plane_index;
    logic       latch_pulse;
    logic [7:0] enable_duty;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [7:0] brightness = '0;

    // model of the block: both frame buffers, buffer select, scan counters, register
    pixel_t     frame_model [0:1][0:PANEL_ROWS-1][0:PANEL_COLUMNS-1];
    logic       display_sel;
    int         shift_col;
    int         scan_row;
    int         scan_plane;
    logic [7:0] panel_brightness;

    // stimulus and expectation stores
    panel_cmd_t    command_queue[$];
    shift_result_t pending_shifts[$];

    // handshakes seen at the last rising edge, used on the falling edge
    bit took_item = 1'b0;
    bit took_result = 1'b0;
    bit steady_run = 1'b0;       // both sides run without gaps while set
    int gap_left = 0;
    int sink_hold = 0;

    // bookkeeping
    int items_queued = 0;
    int items_taken = 0;
    int cfg_writes = 0;
    int mismatches = 0;
    int shifts_checked = 0;
    int n_writes = 0;
    int n_off_panel = 0;
    int n_swaps = 0;
    int n_clears = 0;
    int n_latches = 0;
    logic [7:0] planes_seen = '0;

    led_matrix_scan_driver dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .cmd         (cmd),
        .pix_x       (pix_x),
        .pix_y       (pix_y),
        .red_in      (red_in),
        .green_in    (green_in),
        .blue_in     (blue_in),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .upper_red   (upper_red),
        .upper_green (upper_green),
        .upper_blue  (upper_blue),
        .lower_red   (lower_red),
        .lower_green (lower_green),
        .lower_blue  (lower_blue),
        .row_address (row_address),
        .plane_index (plane_index),
        .latch_pulse (latch_pulse),
        .enable_duty (enable_duty),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .brightness  (brightness)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // hard stop in case a handshake never completes
    initial
    begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    task automatic flag_mismatch(input string what);
        mismatches++;
        $display("mismatch: %s", what);
    endtask

    task automatic check_field(input string name, input logic [7:0] got,
                               input logic [7:0] want);
        if (got !== want)
            flag_mismatch($sformatf("%s at shift %0d: got %0h, want %0h",
                                    name, shifts_checked, got, want));
    endtask

    // gap before the next item on either side
    function automatic int draw_gap();
        return steady_run ? 0 : $urandom_range(0, 15);
    endfunction

    // apply one accepted command to the model; a scan step queues its shift
    task automatic panel_apply(input panel_cmd_t c);
        int            xs;
        int            ys;
        int            col_x;
        int            y_up;
        int            y_lo;
        pixel_t        up;
        pixel_t        lo;
        logic          show;
        logic          latch;
        shift_result_t r;
        xs = $signed(c.pix_x);
        ys = $signed(c.pix_y);
        case (c.op)
            CMD_WRITE:
            begin
                n_writes++;
                // coordinates off the panel leave the buffer alone
                if (xs >= 0 && xs < PANEL_COLUMNS && ys >= 0 && ys < PANEL_ROWS)
                    frame_model[display_sel][ys][xs] = {c.red, c.green, c.blue};
                else
                    n_off_panel++;
            end
            CMD_SWAP:
            begin
                n_swaps++;
                display_sel = ~display_sel;
            end
            CMD_CLEAR:
            begin
                // whole draw buffer goes to zero within the command
                n_clears++;
                for (int y = 0; y < PANEL_ROWS; y++)
                    for (int x = 0; x < PANEL_COLUMNS; x++)
                        frame_model[display_sel][y][x] = '0;
            end
            default:
            begin
                col_x = shift_col % PANEL_COLUMNS;
                // first half of the row shifts rows r+S / r+3S, second half r / r+2S
                if (shift_col >= PANEL_COLUMNS)
                begin
                    y_up = scan_row;
                    y_lo = scan_row + 2 * SCAN_ROWS;
                end
                else
                begin
                    y_up = scan_row + SCAN_ROWS;
                    y_lo = scan_row + 3 * SCAN_ROWS;
                end
                up = frame_model[~display_sel][y_up][col_x];
                lo = frame_model[~display_sel][y_lo][col_x];
                // planes past the colour depth show dark
                show = (scan_plane < COLOR_BITS);
                latch = (shift_col == SHIFTS_PER_ROW - 1);
                r.upper_red   = show & up.red[scan_plane];
                r.upper_green = show & up.green[scan_plane];
                r.upper_blue  = show & up.blue[scan_plane];
                r.lower_red   = show & lo.red[scan_plane];
                r.lower_green = show & lo.green[scan_plane];
                r.lower_blue  = show & lo.blue[scan_plane];
                r.row_address = scan_row[2:0];
                r.plane_index = scan_plane[2:0];
                r.latch_pulse = latch;
                r.enable_duty = latch ? panel_brightness : 8'd0;
                pending_shifts.push_back(r);
                planes_seen[scan_plane] = 1'b1;
                // advance column, then row after the latch, then plane
                if (latch)
                begin
                    n_latches++;
                    shift_col = 0;
                    scan_row++;
                    if (scan_row >= SCAN_ROWS)
                    begin
                        scan_row = 0;
                        scan_plane++;
                        if (scan_plane >= PLANE_COUNT)
                            scan_plane = 0;
                    end
                end
                else
                begin
                    shift_col++;
                end
            end
        endcase
    endtask

    // driver: presents queued items on the falling edge, holds them until taken
    always @(negedge clk)
    begin
        int         gap;
        panel_cmd_t c;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            gap_left = 0;
        end
        else if (!(in_valid && !took_item))
        begin
            // a fresh gap is drawn each time an item has gone in
            gap = took_item ? draw_gap() : gap_left;
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                gap_left = gap - 1;
            end
            else if (command_queue.size() != 0 &&
                     !(command_queue[0].wait_idle && pending_shifts.size() != 0))
            begin
                c = command_queue.pop_front();
                cmd      <= c.op;
                pix_x    <= c.pix_x;
                pix_y    <= c.pix_y;
                red_in   <= c.red;
                green_in <= c.green;
                blue_in  <= c.blue;
                in_valid <= 1'b1;
                gap_left = 0;
            end
            else
            begin
                in_valid <= 1'b0;
                gap_left = 0;
            end
        end
    end

    // receiver: after each result item holds out_ready low for a randomly drawn gap, none in a steady run
    always @(negedge clk)
    begin
        int hold;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            sink_hold = 0;
        end
        else
        begin
            hold = took_result ? draw_gap() : sink_hold;
            if (hold > 0)
            begin
                out_ready <= 1'b0;
                sink_hold = hold - 1;
            end
            else
            begin
                out_ready <= 1'b1;
                sink_hold = 0;
            end
        end
    end

    // monitor: samples every handshake on the rising edge, checks shifts
    // before it feeds the model with a newly accepted command
    always @(posedge clk)
    begin
        shift_result_t want;
        panel_cmd_t    c;
        took_item   <= rst_n && in_valid && (in_ready === 1'b1);
        took_result <= rst_n && (out_valid === 1'b1) && out_ready;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready === 1'b1)
            begin
                panel_brightness = brightness;
                cfg_writes++;
            end
            if (out_valid === 1'b1 && out_ready)
            begin
                if (pending_shifts.size() == 0)
                begin
                    flag_mismatch("result item with no command behind it");
                end
                else
                begin
                    want = pending_shifts.pop_front();
                    check_field("upper_red", upper_red, want.upper_red);
                    check_field("upper_green", upper_green, want.upper_green);
                    check_field("upper_blue", upper_blue, want.upper_blue);
                    check_field("lower_red", lower_red, want.lower_red);
                    check_field("lower_green", lower_green, want.lower_green);
                    check_field("lower_blue", lower_blue, want.lower_blue);
                    check_field("row_address", row_address, want.row_address);
                    check_field("plane_index", plane_index, want.plane_index);
                    check_field("latch_pulse", latch_pulse, want.latch_pulse);
                    check_field("enable_duty", enable_duty, want.enable_duty);
                end
                shifts_checked++;
            end
            if (in_valid && in_ready === 1'b1)
            begin
                c.op        = cmd;
                c.pix_x     = pix_x;
                c.pix_y     = pix_y;
                c.red       = red_in;
                c.green     = green_in;
                c.blue      = blue_in;
                c.wait_idle = 1'b0;
                panel_apply(c);
                items_taken++;
            end
        end
    end

    function automatic panel_cmd_t compose_cmd(input logic [1:0] op, input logic [7:0] x,
                                               input logic [6:0] y, input logic [4:0] r,
                                               input logic [4:0] g, input logic [4:0] b);
        panel_cmd_t c;
        c.op = op;
        c.pix_x = x;
        c.pix_y = y;
        c.red = r;
        c.green = g;
        c.blue = b;
        c.wait_idle = 1'b0;
        return c;
    endfunction

    // mostly writes and scan steps, with the odd swap and clear
    function automatic panel_cmd_t random_cmd();
        panel_cmd_t c;
        int         pick;
        pick = $urandom_range(0, 99);
        if (pick < 40)
            c.op = CMD_WRITE;
        else if (pick < 90)
            c.op = CMD_SCAN;
        else if (pick < 96)
            c.op = CMD_SWAP;
        else
            c.op = CMD_CLEAR;
        // most writes land on the panel, the rest use the full signed range
        if ($urandom_range(0, 6) != 0)
        begin
            c.pix_x = 8'($urandom_range(0, PANEL_COLUMNS - 1));
            c.pix_y = 7'($urandom_range(0, PANEL_ROWS - 1));
        end
        else
        begin
            c.pix_x = 8'($urandom);
            c.pix_y = 7'($urandom);
        end
        c.red = 5'($urandom);
        c.green = 5'($urandom);
        c.blue = 5'($urandom);
        c.wait_idle = ($urandom_range(0, 99) == 0);
        return c;
    endfunction

    task automatic queue_command(input panel_cmd_t c);
        command_queue.push_back(c);
        items_queued++;
    endtask

    task automatic queue_scans(input int count);
        panel_cmd_t c;
        repeat (count)
        begin
            c = random_cmd();
            c.op = CMD_SCAN;
            c.wait_idle = 1'b0;
            queue_command(c);
        end
    endtask

    // wait until every item is in and every shift is out, then let a clear finish
    task automatic drain_block();
        do
            @(negedge clk);
        while (items_taken != items_queued || pending_shifts.size() != 0);
        repeat (4) @(negedge clk);
        while (in_ready !== 1'b1)
            @(negedge clk);
    endtask

    // register write, only ever issued with the block idle
    task automatic load_brightness(input logic [7:0] level);
        int before_count;
        before_count = cfg_writes;
        @(negedge clk);
        cfg_valid <= 1'b1;
        brightness <= level;
        while (cfg_writes == before_count)
            @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        panel_cmd_t c;
        logic [7:0] phase_level [0:4];

        // model reset state
        for (int b = 0; b < 2; b++)
            for (int y = 0; y < PANEL_ROWS; y++)
                for (int x = 0; x < PANEL_COLUMNS; x++)
                    frame_model[b][y][x] = '0;
        display_sel = 1'b0;
        shift_col = 0;
        scan_row = 0;
        scan_plane = 0;
        panel_brightness = BRIGHT_RESET;

        repeat (6) @(negedge clk);
        rst_n <= 1'b1;

        // directed: panel corners, full and zero levels, off-panel writes on every
        // edge, scans of an empty display, swaps and clears
        queue_command(compose_cmd(CMD_SCAN, 8'hff, 7'h7f, 5'h1f, 5'h1f, 5'h1f));
        queue_command(compose_cmd(CMD_WRITE, 8'd0, 7'd8, 5'h1f, 5'h1f, 5'h1f));
        queue_command(compose_cmd(CMD_WRITE, 8'd0, 7'd24, 5'h15, 5'h0a, 5'h05));
        queue_command(compose_cmd(CMD_WRITE, 8'd0, 7'd0, 5'h1f, 5'h00, 5'h1f));
        queue_command(compose_cmd(CMD_WRITE, 8'd63, 7'd31, 5'h00, 5'h1f, 5'h00));
        queue_command(compose_cmd(CMD_WRITE, 8'd63, 7'd0, 5'h01, 5'h02, 5'h04));
        queue_command(compose_cmd(CMD_WRITE, 8'd0, 7'd31, 5'h10, 5'h08, 5'h1f));
        queue_command(compose_cmd(CMD_WRITE, 8'h80, 7'd0, 5'h1f, 5'h1f, 5'h1f));
        queue_command(compose_cmd(CMD_WRITE, 8'h7f, 7'h3f, 5'h1f, 5'h1f, 5'h1f));
        queue_command(compose_cmd(CMD_WRITE, 8'd64, 7'd5, 5'h1f, 5'h1f, 5'h1f));
        queue_command(compose_cmd(CMD_WRITE, 8'd5, 7'd32, 5'h1f, 5'h1f, 5'h1f));
        queue_command(compose_cmd(CMD_WRITE, 8'hff, 7'h7f, 5'h1f, 5'h1f, 5'h1f));
        queue_command(compose_cmd(CMD_WRITE, 8'd10, 7'h40, 5'h1f, 5'h1f, 5'h1f));
        queue_command(compose_cmd(CMD_SCAN, 8'd0, 7'd0, 5'h00, 5'h00, 5'h00));
        queue_command(compose_cmd(CMD_SWAP, 8'hff, 7'h7f, 5'h1f, 5'h1f, 5'h1f));
        queue_command(compose_cmd(CMD_SCAN, 8'd0, 7'd0, 5'h00, 5'h00, 5'h00));
        queue_command(compose_cmd(CMD_SCAN, 8'hff, 7'h7f, 5'h1f, 5'h1f, 5'h1f));
        queue_command(compose_cmd(CMD_SCAN, 8'd0, 7'd0, 5'h00, 5'h00, 5'h00));
        queue_command(compose_cmd(CMD_CLEAR, 8'd0, 7'd0, 5'h00, 5'h00, 5'h00));
        queue_command(compose_cmd(CMD_SWAP, 8'd0, 7'd0, 5'h00, 5'h00, 5'h00));
        queue_command(compose_cmd(CMD_SCAN, 8'd0, 7'd0, 5'h00, 5'h00, 5'h00));
        queue_command(compose_cmd(CMD_SWAP, 8'd0, 7'd0, 5'h00, 5'h00, 5'h00));
        queue_command(compose_cmd(CMD_CLEAR, 8'hff, 7'h7f, 5'h1f, 5'h1f, 5'h1f));
        queue_command(compose_cmd(CMD_SCAN, 8'd0, 7'd0, 5'h00, 5'h00, 5'h00));
        drain_block();

        // random phases, each under its own brightness; every phase ends on a
        // full row of shifts so that a latch carries the new duty
        phase_level[0] = 8'd0;
        phase_level[1] = 8'd255;
        phase_level[2] = 8'd1;
        phase_level[3] = 8'($urandom);
        phase_level[4] = 8'd128;
        for (int p = 0; p < 5; p++)
        begin
            load_brightness(phase_level[p]);
            repeat (80)
                queue_command(random_cmd());
            queue_scans(SHIFTS_PER_ROW);
            drain_block();
        end

        // fill part of the draw buffer, show it, then scan two full rows back
        // to back with neither side idling
        load_brightness(8'($urandom));
        repeat (100)
        begin
            c = random_cmd();
            c.op = CMD_WRITE;
            queue_command(c);
        end
        queue_command(compose_cmd(CMD_SWAP, 8'd0, 7'd0, 5'h00, 5'h00, 5'h00));
        drain_block();
        steady_run = 1'b1;
        queue_scans(2 * SHIFTS_PER_ROW);
        drain_block();
        steady_run = 1'b0;

        // tail: nothing more may come out
        repeat (16) @(negedge clk);
        if (pending_shifts.size() != 0)
            flag_mismatch($sformatf("%0d shifts never came out", pending_shifts.size()));

        $display("covered %0d commands: %0d writes (%0d off panel), %0d swaps, %0d clears",
                 items_taken, n_writes, n_off_panel, n_swaps, n_clears);
        $display("%0d shifts checked, %0d row latches, %0d brightness loads, planes %b",
                 shifts_checked, n_latches, cfg_writes, planes_seen);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// File: led_matrix_scan_driver.f
+incdir+hdl
hdl/lmsd_pkg.sv
hdl/led_matrix_scan_driver.sv
hdl/lmsd_checker.sv
bench/tb_led_matrix_scan_driver.sv
